>>> rtl/utcld_pkg.sv
package utcld_pkg;

  // offset band in minutes, either side of zero
  localparam int OFFSET_BAND = 840;

  // bias that lifts an in-band offset to a positive value, 15 hours
  localparam logic [12:0] OFFSET_BIAS = 13'd900;

  // reciprocal of 60 scaled by 2^17, exact for values up to 1740
  localparam logic [11:0] RECIP60       = 12'd2185;
  localparam int unsigned RECIP60_SHIFT = 17;

  // hour part of the bias
  localparam logic [5:0] BIAS_HOURS = 6'd15;

  typedef struct packed {
    logic [15:0] in_year;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
    logic [4:0]  in_hour;
    logic [5:0]  in_minute;
  } utcld_in_t;

  typedef struct packed {
    logic [15:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic        offset_rejected;
  } utcld_out_t;

  // offset held as whole hours plus 0..59 minutes
  typedef struct packed {
    logic              rej;
    logic signed [4:0] off_h;
    logic [5:0]        off_m;
  } utcld_cfg_t;

endpackage

>>> rtl/utc_to_local_date_time.sv
// pipeline: input register then result register; out_valid rises when an item loads into the
// result register, which a stall on the result channel can delay
// throughput: one conversion per cycle while out_stall is low, set by the single pass through the conversion logic
// reset: synchronous active-low rst_n empties both stages and sets the offset to 0 minutes
// configuration is taken at the edge where cfg_valid is high, cfg_ready is always high
module utc_to_local_date_time (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  utcld_pkg::utcld_in_t  in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output utcld_pkg::utcld_out_t out_data,
  // offset register write
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic signed [11:0]    cfg_data
);

  utcld_pkg::utcld_cfg_t cfg;

  // stage one: input register
  logic                  in_valid_r;
  utcld_pkg::utcld_in_t  in_data_r;

  // stage two: result register
  logic                  out_valid_r;
  utcld_pkg::utcld_out_t out_data_r;
  utcld_pkg::utcld_out_t out_data_nxt;

  logic out_adv;
  logic in_adv;

  assign cfg_ready = 1'b1;

  // offset register, kept as hours and minutes
  utcld_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  // date-time arithmetic between the two registers
  utcld_conv u_conv (
    .in_i  (in_data_r),
    .cfg_i (cfg),
    .out_o (out_data_nxt)
  );

  // a stage moves on when the stage after it is empty or its transfer happens now
  assign out_adv  = !out_valid_r || !out_stall;
  assign in_adv   = !in_valid_r || out_adv;
  assign in_stall = !in_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_adv) begin
        in_valid_r <= in_valid;
      end
      if (out_adv) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  // payload registers load only with a fresh item
  always_ff @(posedge clk) begin
    if (in_adv && in_valid) begin
      in_data_r <= in_data;
    end
    if (out_adv && in_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/utcld_cfg.sv
module utcld_cfg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic signed [11:0]    cfg_data,
  output utcld_pkg::utcld_cfg_t cfg_o
);

  utcld_pkg::utcld_cfg_t cfg_r;
  utcld_pkg::utcld_cfg_t cfg_nxt;

  logic [12:0] biased;
  logic [10:0] x;
  logic [22:0] prod;
  logic [4:0]  q;
  logic [10:0] q60;
  logic [10:0] rem;

  // split offset + 900 into hours and minutes via reciprocal multiply
  always_comb begin
    biased = {cfg_data[11], cfg_data} + utcld_pkg::OFFSET_BIAS;
    x      = biased[10:0];
    prod   = 23'(x) * 23'(utcld_pkg::RECIP60);
    q      = prod[utcld_pkg::RECIP60_SHIFT +: 5];
    q60    = 11'({q, 6'b000000}) - 11'({q, 2'b00});
    rem    = x - q60;

    cfg_nxt.rej   = (cfg_data < -utcld_pkg::OFFSET_BAND) ||
                    (cfg_data > utcld_pkg::OFFSET_BAND);
    cfg_nxt.off_h = 5'(6'(q) - utcld_pkg::BIAS_HOURS);
    cfg_nxt.off_m = rem[5:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

>>> rtl/utcld_conv.sv
module utcld_conv (
  input  utcld_pkg::utcld_in_t  in_i,
  input  utcld_pkg::utcld_cfg_t cfg_i,
  output utcld_pkg::utcld_out_t out_o
);

  localparam logic [13:0] INV25     = 14'd7209;
  localparam logic [13:0] DIV25_MAX = 14'd655;
  localparam logic [3:0]  JANUARY   = 4'd1;
  localparam logic [3:0]  FEBRUARY  = 4'd2;
  localparam logic [3:0]  DECEMBER  = 4'd12;
  localparam logic [6:0]  TWO_HOURS = 7'd120;
  localparam logic [6:0]  ONE_HOUR  = 7'd60;
  localparam logic [5:0]  DAY_HOURS = 6'd24;

  // multiple of 25 test through the inverse of 25 modulo 2^14
  function automatic logic div25(input logic [13:0] v);
    logic [27:0] p;
    p = 28'(v) * 28'(INV25);
    return p[13:0] <= DIV25_MAX;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                      len = 5'd30;
      FEBRUARY:                                     len = leap ? 5'd29 : 5'd28;
      default:                                      len = 5'd0;
    endcase
    return len;
  endfunction

  logic              leap;
  logic [6:0]        ms;
  logic [1:0]        carry;
  logic [6:0]        mn;
  logic [6:0]        hs;
  logic              back;
  logic              fwd;
  logic [4:0]        len_cur;
  logic [3:0]        m_prev;
  logic [4:0]        len_prev;
  logic [15:0]       y;
  logic [3:0]        m;
  logic [4:0]        d;
  logic [6:0]        h_adj;

  always_comb begin
    leap = ((in_i.in_year[1:0] == 2'b00) && !div25(in_i.in_year[15:2])) ||
           ((in_i.in_year[3:0] == 4'b0000) && div25({2'b00, in_i.in_year[15:4]}));

    // minute sum carries at most two hours
    ms = 7'(in_i.in_minute) + 7'(cfg_i.off_m);
    if (ms >= TWO_HOURS) begin
      carry = 2'd2;
      mn    = ms - TWO_HOURS;
    end else if (ms >= ONE_HOUR) begin
      carry = 2'd1;
      mn    = ms - ONE_HOUR;
    end else begin
      carry = 2'd0;
      mn    = ms;
    end

    hs   = 7'(in_i.in_hour) + {{2{cfg_i.off_h[4]}}, cfg_i.off_h} + 7'(carry);
    back = hs[6];
    fwd  = !hs[6] && (hs[5:0] >= DAY_HOURS);

    len_cur  = month_len(in_i.in_month, leap);
    m_prev   = (in_i.in_month > JANUARY) ? in_i.in_month - 4'd1 : DECEMBER;
    len_prev = month_len(m_prev, leap);

    y     = in_i.in_year;
    m     = in_i.in_month;
    d     = in_i.in_day;
    h_adj = hs;

    if (back) begin
      h_adj = hs + 7'(DAY_HOURS);
      if (in_i.in_day > 5'd1) begin
        d = in_i.in_day - 5'd1;
      end else begin
        m = m_prev;
        if (in_i.in_month <= JANUARY) begin
          y = in_i.in_year - 16'd1;
        end
        d = (len_prev != 5'd0) ? len_prev : 5'd1;
      end
    end else if (fwd) begin
      h_adj = hs - 7'(DAY_HOURS);
      if ((len_cur != 5'd0) && (in_i.in_day < len_cur)) begin
        d = in_i.in_day + 5'd1;
      end else begin
        d = 5'd1;
        if (in_i.in_month < DECEMBER) begin
          m = in_i.in_month + 4'd1;
        end else begin
          m = JANUARY;
          y = in_i.in_year + 16'd1;
        end
      end
    end

    if (cfg_i.rej) begin
      out_o.out_year        = in_i.in_year;
      out_o.out_month       = in_i.in_month;
      out_o.out_day         = in_i.in_day;
      out_o.out_hour        = in_i.in_hour;
      out_o.out_minute      = in_i.in_minute;
      out_o.offset_rejected = 1'b1;
    end else begin
      out_o.out_year        = y;
      out_o.out_month       = m;
      out_o.out_day         = d;
      out_o.out_hour        = h_adj[4:0];
      out_o.out_minute      = mn[5:0];
      out_o.offset_rejected = 1'b0;
    end
  end

endmodule

>>> rtl/utcld_checker.sv
module utcld_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input utcld_pkg::utcld_out_t out_data
);

  // a held result stays on the port
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // the input side stalls only with a result waiting
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

  // a converted time always lands inside the day
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.offset_rejected |->
      (out_data.out_hour < 5'd24) && (out_data.out_minute < 6'd60))
    else $error("converted time out of range");

  // reset empties the result stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind utc_to_local_date_time utcld_checker u_utcld_checker (.*);
